// File: rtl/core/rrtr_pkg.sv
package rrtr_pkg;

    localparam int FRAC_BITS_DEF = 40;
    localparam int MAX_TERMS_DEF = 32;

    localparam int RATE_W  = 48;
    localparam int VAL_W   = 31;
    localparam int CFG_IW  = 2;
    localparam int DIV_W   = 49;           // holds 2^FRAC_BITS at the widest setting
    localparam int BAND_W  = 56;           // 130 << 48 fits
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 80;
    localparam int ERR_SHIFT = 30;

    localparam logic [PROD_W:0] NUM_LIMIT = (PROD_W+1)'(64'd2000000000);
    localparam logic [PROD_W:0] DEN_LIMIT = (PROD_W+1)'(64'd100000000);

    localparam logic [VAL_W-1:0] FB_NUM_PAL  = VAL_W'(50);
    localparam logic [VAL_W-1:0] FB_NUM_NTSC = VAL_W'(60);
    localparam logic [VAL_W-1:0] FB_DEN      = VAL_W'(1);

    localparam logic [CFG_IW-1:0] CFG_DECL_NUM   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_DECL_DEN   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_REGION_PAL = 2'd2;

    typedef enum logic [1:0] {
        MS_H   = 2'd0,
        MS_K   = 2'd1,
        MS_RLO = 2'd2,
        MS_RHI = 2'd3
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  div_step;
        t_msel msel;
        logic  num_ld;
        logic  den_ld;
        logic  acc_lo;
        logic  acc_hi;
        logic  update;
        logic  emit;
        logic  emit_fb;
    } t_dp_cmd;

    typedef struct packed {
        logic in_band;
        logic div_last;
        logic w_big;
        logic over;
        logic close;
        logic rem_zero;
        logic term_last;
    } t_dp_stat;

endpackage

// File: rtl/core/rrtr_ctrl.sv
module rrtr_ctrl
    import rrtr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_BAND = 12'b000000000010,
        S_DIV  = 12'b000000000100,
        S_MULH = 12'b000000001000,
        S_MULK = 12'b000000010000,
        S_DEN  = 12'b000000100000,
        S_RLO  = 12'b000001000000,
        S_RHI  = 12'b000010000000,
        S_ACC  = 12'b000100000000,
        S_CMP  = 12'b001000000000,
        S_DONE = 12'b010000000000,
        S_SPR  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.msel = MS_RLO;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_BAND;
                end
            end
            S_BAND: begin
                if (i_stat.in_band) begin
                    n_state = S_DIV;
                end else begin
                    o_cmd.emit_fb = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_MULH;
            end
            S_MULH: begin
                o_cmd.msel = MS_H;
                n_state = i_stat.w_big ? S_DONE : S_MULK;
            end
            S_MULK: begin
                o_cmd.msel   = MS_K;
                o_cmd.num_ld = 1'b1;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den_ld = 1'b1;
                n_state = S_RLO;
            end
            S_RLO: begin
                o_cmd.msel = MS_RLO;
                n_state = i_stat.over ? S_DONE : S_RHI;
            end
            S_RHI: begin
                o_cmd.msel   = MS_RHI;
                o_cmd.acc_lo = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_hi = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                // take the convergent, then stop or start the next term
                o_cmd.update = 1'b1;
                if (i_stat.close || i_stat.rem_zero || i_stat.term_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/rrtr_dp.sv
module rrtr_dp
    import rrtr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]  i_cfg_data,
    input  logic [RATE_W-1:0] i_rate_q40,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_ratio_num,
    output logic [VAL_W-1:0]  o_ratio_den,
    output logic              o_used_fallback
);

    localparam int CNT_W  = $clog2(DIV_W);
    localparam int TERM_W = $clog2(MAX_TERMS + 1);
    localparam logic [DIV_W-1:0]  ONE     = DIV_W'(1) << FRAC_BITS;
    localparam logic [BAND_W-1:0] BAND_LO = BAND_W'(20) << FRAC_BITS;
    localparam logic [BAND_W-1:0] BAND_HI = BAND_W'(130) << FRAC_BITS;

    logic [VAL_W-1:0]  r_decl_num, r_decl_den;
    logic              r_pal;
    logic [RATE_W-1:0] r_rate;
    logic [DIV_W-1:0]  r_b, r_dq, r_dr;
    logic [CNT_W-1:0]  r_cnt;
    logic [TERM_W-1:0] r_i;
    logic [VAL_W-1:0]  r_h0, r_h1, r_k0, r_k1, r_num, r_den;
    logic              r_over;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_done;
    logic [VAL_W-1:0]  r_out_num, r_out_den;
    logic              r_out_fb;

    logic [DIV_W:0]    div_tmp;
    logic              div_ge;
    logic [MUL_W-1:0]  op_a, op_b;
    logic [PROD_W:0]   num_wide, den_wide;
    logic [ACC_W-1:0]  rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl_num <= '0;
            r_decl_den <= '0;
            r_pal      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DECL_NUM:   r_decl_num <= i_cfg_data;
                CFG_DECL_DEN:   r_decl_den <= i_cfg_data;
                CFG_REGION_PAL: r_pal      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // restoring divider, one quotient bit per cycle
    assign div_tmp = {r_dr, r_dq[DIV_W-1]};
    assign div_ge  = (div_tmp >= {1'b0, r_b});

    always_comb begin
        case (i_cmd.msel)
            MS_H:    begin op_a = r_dq[MUL_W-1:0]; op_b = MUL_W'(r_h1); end
            MS_K:    begin op_a = r_dq[MUL_W-1:0]; op_b = MUL_W'(r_k1); end
            MS_RLO:  begin op_a = r_rate[MUL_W-1:0]; op_b = MUL_W'(r_den); end
            MS_RHI:  begin op_a = MUL_W'(r_rate[RATE_W-1:MUL_W]); op_b = MUL_W'(r_den); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign num_wide = {1'b0, r_prod} + (PROD_W+1)'(r_h0);
    assign den_wide = {1'b0, r_prod} + (PROD_W+1)'(r_k0);
    assign rem_sh   = ACC_W'({r_dr, ERR_SHIFT'(0)});

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (i_cmd.load) begin
            r_rate <= i_rate_q40;
            r_b    <= ONE;
            r_dq   <= DIV_W'(i_rate_q40);
            r_dr   <= '0;
            r_cnt  <= '0;
            r_h1   <= VAL_W'(1);
            r_h0   <= '0;
            r_k1   <= '0;
            r_k0   <= VAL_W'(1);
        end
        if (i_cmd.div_step) begin
            r_dr  <= div_ge ? DIV_W'(div_tmp - {1'b0, r_b}) : div_tmp[DIV_W-1:0];
            r_dq  <= {r_dq[DIV_W-2:0], div_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.num_ld) begin
            r_num  <= num_wide[VAL_W-1:0];
            r_over <= (num_wide > NUM_LIMIT);
        end
        if (i_cmd.den_ld) begin
            r_den  <= den_wide[VAL_W-1:0];
            r_over <= r_over | (den_wide > DEN_LIMIT);
        end
        if (i_cmd.acc_lo) r_acc <= ACC_W'(r_prod);
        if (i_cmd.acc_hi) r_acc <= r_acc + {r_prod[ACC_W-MUL_W-1:0], MUL_W'(0)};
        if (i_cmd.update) begin
            r_h0  <= r_h1;
            r_k0  <= r_k1;
            r_h1  <= r_num;
            r_k1  <= r_den;
            r_b   <= r_dr;
            r_dq  <= r_b;
            r_dr  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.emit) begin
            r_out_num <= r_h1;
            r_out_den <= r_k1;
            r_out_fb  <= 1'b0;
        end
        if (i_cmd.emit_fb) begin
            if (r_decl_num != '0 && r_decl_den != '0) begin
                r_out_num <= r_decl_num;
                r_out_den <= r_decl_den;
            end else begin
                r_out_num <= r_pal ? FB_NUM_PAL : FB_NUM_NTSC;
                r_out_den <= FB_DEN;
            end
            r_out_fb <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= i_cmd.emit | i_cmd.emit_fb;
            if (i_cmd.load) begin
                r_i <= '0;
            end else if (i_cmd.update) begin
                r_i <= r_i + TERM_W'(1);
            end
        end
    end

    assign o_stat.in_band   = (BAND_W'(r_rate) > BAND_LO) && (BAND_W'(r_rate) < BAND_HI);
    assign o_stat.div_last  = (r_cnt == CNT_W'(DIV_W - 1));
    assign o_stat.w_big     = |r_dq[DIV_W-1:MUL_W];
    assign o_stat.over      = r_over;
    assign o_stat.close     = (rem_sh < r_acc);
    assign o_stat.rem_zero  = (r_dr == '0);
    assign o_stat.term_last = (r_i == TERM_W'(MAX_TERMS - 1));

    assign o_done          = r_done;
    assign o_ratio_num     = r_out_num;
    assign o_ratio_den     = r_out_den;
    assign o_used_fallback = r_out_fb;

endmodule

// File: rtl/core/refresh_rate_to_rational_unit.sv
// Refresh rate to rational converter.
// Command channel: pulse start with i_rate_q40 (unsigned, FRAC_BITS fraction
// bits) while busy is low; the rate is captured in that cycle and busy rises.
// Result: o_ratio_num / o_ratio_den / o_used_fallback valid for exactly one
// cycle with o_done high; the receiver cannot stall, so it must take the
// transfer then. busy falls in the same cycle o_done rises.
// Out-of-band rates give the declared or 50/60 fallback. In-band rates run a
// continued-fraction expansion; each term uses the bit-serial divider plus
// one shared 32x32 multiplier used four times and a compare. Up to MAX_TERMS
// terms are computed.
// One item at a time; the next start is taken once busy is low.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data, written in any cycle while
// the unit is idle; index 3 is ignored.
// Reset (synchronous, active low) clears the configuration to zero and
// returns the unit to idle with no result pending.
module refresh_rate_to_rational_unit
    import rrtr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [RATE_W-1:0] i_rate_q40,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_ratio_num,
    output logic [VAL_W-1:0]  o_ratio_den,
    output logic              o_used_fallback
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rrtr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rrtr_dp #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_rate_q40      (i_rate_q40),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_done          (o_done),
        .o_ratio_num     (o_ratio_num),
        .o_ratio_den     (o_ratio_den),
        .o_used_fallback (o_used_fallback)
    );

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_den_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_used_fallback) |->
            (o_ratio_den != '0 && o_ratio_den <= VAL_W'(100000000)))
        else $error("convergent denominator out of range");

    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_used_fallback) |-> (o_ratio_num <= VAL_W'(2000000000)))
        else $error("convergent numerator out of range");

endmodule

// File: tb/sv/ratio_checker.sv
`timescale 1ns / 1ps

module ratio_checker
    import rrtr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [RATE_W-1:0] i_rate_q40,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]  i_cfg_data,
    input  logic              o_done,
    input  logic [VAL_W-1:0]  o_ratio_num,
    input  logic [VAL_W-1:0]  o_ratio_den,
    input  logic              o_used_fallback,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int TERMS = MAX_TERMS_DEF;

    typedef struct packed {
        logic [VAL_W-1:0] num;
        logic [VAL_W-1:0] den;
        logic             fb;
    } t_ratio;

    t_ratio           ratio_q[$];
    logic [VAL_W-1:0] decl_num, decl_den;
    logic             pal;
    int               fails;

    assign o_fail_count = fails;

    function automatic t_ratio rate_to_ratio(input logic [RATE_W-1:0] rate);
        t_ratio      r;
        logic [63:0] h1, h0, k1, k0, a, b, whole, rem, num, den;
        logic [127:0] lhs, rhs;
        h1 = 1; h0 = 0; k1 = 0; k0 = 1;
        a = 64'(rate); b = 64'd1 << FRAC;
        if (!(64'(rate) > (64'd20 << FRAC) && 64'(rate) < (64'd130 << FRAC))) begin
            if (decl_num != 0 && decl_den != 0) begin
                r.num = decl_num; r.den = decl_den;
            end else begin
                r.num = pal ? 31'd50 : 31'd60; r.den = 31'd1;
            end
            r.fb = 1'b1;
            return r;
        end
        for (int i = 0; i < TERMS; i++) begin
            if (b == 0) break;
            whole = a / b;
            rem = a - whole * b;
            if (whole > 64'd2000000000 / h1) break;
            num = whole * h1 + h0;
            if (num > 64'd2000000000) break;
            if (k1 == 0) begin
                den = k0;
            end else begin
                if (whole > 64'd100000000 / k1) break;
                den = whole * k1 + k0;
            end
            if (den > 64'd100000000) break;
            h0 = h1; k0 = k1; h1 = num; k1 = den;
            lhs = 128'(rem) << ERR_SHIFT;
            rhs = 128'(rate) * 128'(den);
            if (lhs < rhs) break;
            if (rem == 0) break;
            a = b; b = rem;
        end
        r.num = h1[VAL_W-1:0]; r.den = k1[VAL_W-1:0]; r.fb = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_ratio want;
        if (!i_rst_n) begin
            decl_num <= '0; decl_den <= '0; pal <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DECL_NUM:   decl_num <= i_cfg_data;
                    CFG_DECL_DEN:   decl_den <= i_cfg_data;
                    CFG_REGION_PAL: pal <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_done) begin
                if (ratio_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = ratio_q.pop_front();
                    if (o_ratio_num !== want.num)
                        report_mismatch($sformatf("num %0d want %0d", o_ratio_num, want.num));
                    if (o_ratio_den !== want.den)
                        report_mismatch($sformatf("den %0d want %0d", o_ratio_den, want.den));
                    if (o_used_fallback !== want.fb)
                        report_mismatch($sformatf("fallback %0b want %0b",
                                                  o_used_fallback, want.fb));
                end
            end
            // config is only written while idle, so current values apply
            if (start && !busy) ratio_q.insert(ratio_q.size(), rate_to_ratio(i_rate_q40));
        end
        o_pending = ratio_q.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rrtr_pkg::*;

    localparam longint ONE = 64'd1 << FRAC_BITS_DEF;
    localparam int     LIMIT = 4000000;
    localparam logic [CFG_IW-1:0] CFG_BAD_IDX = 2'd3;

    logic              i_clk, i_rst_n, start, busy;
    logic [RATE_W-1:0] i_rate_q40;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [VAL_W-1:0]  i_cfg_data;
    logic              o_done, o_used_fallback;
    logic [VAL_W-1:0]  o_ratio_num, o_ratio_den;
    int                fail_count, pending, cycles;

    refresh_rate_to_rational_unit DUT (.*);

    ratio_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_rate_q40, .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .o_done, .o_ratio_num, .o_ratio_den, .o_used_fallback,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    initial begin
        i_rst_n = 1'b0; start = 1'b0; i_rate_q40 = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end
    initial cycles = 0;

    // start is left high after the accepting edge; a gap or drain lowers it
    task automatic send_rate(input logic [RATE_W-1:0] rate);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_rate_q40 <= rate;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [VAL_W-1:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [RATE_W-1:0] rand_rate();
        logic [RATE_W-1:0] r;
        int sel;
        sel = $urandom_range(0, 9);
        r = RATE_W'({$urandom, $urandom});
        if (sel < 7)
            r = RATE_W'(ONE * 21) + RATE_W'({$urandom, $urandom} % (ONE * 108));
        else if (sel == 7)
            r = RATE_W'($urandom_range(21, 129)) << FRAC_BITS_DEF;
        return r;
    endfunction

    initial begin
        logic [RATE_W-1:0] dir[$];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir = '{48'd0, '1, RATE_W'(ONE * 20), RATE_W'(ONE * 20 + 1),
                RATE_W'(ONE * 130 - 1), RATE_W'(ONE * 130), RATE_W'(ONE * 60),
                RATE_W'(ONE * 50 + ONE / 2), 48'h3B_BF6B_8C3F_1A, 48'h3B_EF6B_0000_01,
                48'h55_5555_5555_55, 48'hAA_AAAA_AAAA_AA, RATE_W'(ONE * 129 + ONE - 2),
                48'h32_0000_0001_00, 48'h14_0000_0000_01};
        foreach (dir[i]) send_rate(dir[i]);
        drain();
        write_reg(CFG_REGION_PAL, 31'h7FFF_FFFF);
        write_reg(CFG_DECL_NUM, 31'd60000);
        send_rate('1);
        send_rate(48'd5);
        drain();
        write_reg(CFG_DECL_DEN, 31'd1001);
        write_reg(CFG_BAD_IDX, 31'h1234);
        send_rate('1);
        send_rate(RATE_W'(ONE * 59));
        drain();
        write_reg(CFG_DECL_NUM, 31'h7FFF_FFFF);
        write_reg(CFG_DECL_DEN, 31'h7FFF_FFFF);
        write_reg(CFG_REGION_PAL, 31'd0);
        send_rate(48'd1);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            write_reg(CFG_DECL_NUM, (phase % 3 == 0) ? 31'd0 : VAL_W'($urandom));
            write_reg(CFG_DECL_DEN, (phase % 2 == 0) ? VAL_W'($urandom) : 31'd0);
            write_reg(CFG_REGION_PAL, VAL_W'($urandom));
            for (int i = 0; i < 50; i++) send_rate(rand_rate());
        end
        drain();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/rrtr_pkg.sv
rtl/core/rrtr_ctrl.sv
rtl/core/rrtr_dp.sv
rtl/core/refresh_rate_to_rational_unit.sv
tb/sv/ratio_checker.sv
tb/sv/testbench.sv
